>>> rtl/core/itoa_pkg.sv
// shared types, constants and elaboration helpers for the integer to decimal text unit
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS      = 20;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // bcd digits at or above this value get the add-3 correction before each shift
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_SIGN,
        ST_DIGIT
    } back_state_t;

    // number of decimal digits of the largest magnitude, 2^(width-1)
    function automatic int digit_count(input int width);
        longint unsigned max_mag;
        longint unsigned pow;
        int              n;
        max_mag = longint'(1) << (width - 1);
        pow     = 1;
        n       = 0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (pow <= max_mag) begin
                n   = n + 1;
                pow = pow * 10;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/itoa_front.sv
// front end: takes input items and splits them into sign and magnitude
module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_WIDTH-1:0] s_tdata,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [VALUE_WIDTH:0]   push_entry
);
    import itoa_pkg::*;

    logic [VALUE_WIDTH-1:0] value;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;

    assign value     = s_tdata[VALUE_WIDTH-1:0];
    assign negative  = value[VALUE_WIDTH-1];
    // most negative value negates to 2^(width-1), which still fits unsigned
    assign magnitude = negative ? (~value + VALUE_WIDTH'(1)) : value;

    assign push_valid = s_tvalid & aresetn;
    assign s_tready   = push_ready & aresetn;
    assign push_entry = {negative, magnitude};

endmodule

>>> rtl/core/itoa_queue.sv
// two-entry queue between the front end and the converter
module itoa_queue #(
    parameter int ENTRY_WIDTH = itoa_pkg::VALUE_WIDTH_DEF + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  logic [ENTRY_WIDTH-1:0] push_entry,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output logic [ENTRY_WIDTH-1:0] pop_entry
);
    import itoa_pkg::*;

    localparam int DEPTH = 2;

    logic [ENTRY_WIDTH-1:0] store_reg [DEPTH];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = store_reg[rd_ptr_reg];

    assign do_push = push_valid & push_ready;
    assign do_pop  = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/itoa_back.sv
// back end: bit-serial binary to bcd conversion and character output
module itoa_back #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [VALUE_WIDTH:0] pop_entry,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import itoa_pkg::*;

    localparam int NDIG  = digit_count(VALUE_WIDTH);
    localparam int BCD_W = NDIG * 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(NDIG);

    back_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic [BCD_W-1:0]       bcd_adj;
    logic [IDX_W-1:0]       lead_idx;
    logic [3:0]             cur_digit;

    assign out_free = !out_valid_reg || m_tready;
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    // add-3 correction on every bcd digit at or above BCD_ADJ_LIMIT
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + BCD_ADJ_ADD;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // highest nonzero digit, zero maps to the lowest digit
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    neg_next   = pop_entry[VALUE_WIDTH];
                    mag_next   = pop_entry[VALUE_WIDTH-1:0];
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD: begin
                idx_next   = lead_idx;
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {4'd0, cur_digit};
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_unit.sv
// top level of the signed integer to decimal ascii text unit
//
//  channel | dir | tdata                        | tlast
//  s_      | in  | value [VALUE_WIDTH-1:0]      | -
//  m_      | out | char_code [7:0]              | last character of the number
//
// each number leaves the queue, passes through the bit-serial bcd converter, then the
// leading digit is found and the characters follow one per cycle while m_tready allows
// a two-entry queue lets the input side accept while the converter is busy
// aresetn is synchronous and clears the queue, the sequencer and the output valid
// m_tready low holds the output register and stalls the converter at its next character
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_WIDTH-1:0] s_tdata,   // value, zero padded to bytes
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // char_code
    output logic                   m_tlast
);

    logic                 push_valid;
    logic                 push_ready;
    logic [VALUE_WIDTH:0] push_entry;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [VALUE_WIDTH:0] pop_entry;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TDATA_WIDTH (TDATA_WIDTH)
    ) u_front (
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    itoa_queue #(
        .ENTRY_WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
